[rtl/rcccdm_pkg.sv]
// ============================================================================
// rcccdm_pkg: shared constants and types for the RCCC demosaic
// Geometry limits, field widths, register indexes and the step record that
// passes from the front end to the back end.
// ============================================================================
package rcccdm_pkg;

    // geometry and pixel format
    localparam int MAX_COLS    = 2048;
    localparam int MAX_ROWS    = 4096;
    localparam int MIN_DIM     = 4;
    localparam int PIX_W       = 12;
    localparam int WIN         = 5;
    localparam int STORE_ROWS  = WIN - 1;
    localparam int LINE_W      = STORE_ROWS * PIX_W;
    localparam int COL_AW      = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COLS_W      = $clog2(MAX_COLS + 1);
    localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
    localparam int DIM_W       = 16;
    localparam int TDATA_W     = ((PIX_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_COLS_W  = 12;
    localparam int CFG_ROWS_W  = 13;
    localparam int ORDER_W     = 2;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 2'd2;

    // input kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // border mirroring along one axis
    typedef struct packed {
        logic far_a_fwd;    // distance-2 low side taken from +2
        logic far_b_back;   // distance-2 high side taken from -2
        logic near_a_fwd;   // distance-1 low side taken from +1
        logic near_b_back;  // distance-1 high side taken from -1
    } mirror_t;

    // one raster step handed to the back end
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [COL_AW-1:0] addr;
        logic              emit;
        logic              last;
        logic              red;
        mirror_t           h;
        mirror_t           v;
    } step_t;

    function automatic mirror_t mirror_flags(input logic [DIM_W-1:0] pos,
                                             input logic [DIM_W-1:0] n);
        mirror_t        m;
        logic [DIM_W:0] p4;
        logic [DIM_W:0] p1;
        p4 = {1'b0, pos} + (DIM_W+1)'(4);
        p1 = {1'b0, pos} + (DIM_W+1)'(1);
        m.far_a_fwd   = pos < DIM_W'(2);
        m.far_b_back  = (pos >= DIM_W'(2)) && (p4 > {1'b0, n});
        m.near_a_fwd  = pos == '0;
        m.near_b_back = p1 >= {1'b0, n};
        return m;
    endfunction

endpackage

[rtl/rccc_edge_directed_demosaic.sv]
// ============================================================================
// rccc_edge_directed_demosaic: edge-directed RCCC demosaic, top level
// Streams a raster RCCC frame and replaces each red-site pixel by a clear
// estimate taken along the flatter axis of a 5x5 neighbourhood.
// ============================================================================
// Takes one transaction per clock and gives one pixel per clock once the
// pipeline is full, unless the queue fills or the output is held; the line
// store is a single-port-per-side column memory read once and written once
// per step, which sets that rate. Pixels come out 2*cols+2 steps behind the
// input; after the last input pixel of a frame, send drain transactions
// (tuser high), one per remaining pixel, until tlast is seen. Pixels sent
// while a drain is owed and drains sent with nothing owed are swallowed.
// Geometry and colour-order writes take effect at the first pixel of the
// next frame. There is no clearing pass after reset: borders are mirrored,
// so stale store contents never reach the output.
module rccc_edge_directed_demosaic
    import rcccdm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [11:0] pixel_in
    input  logic                 s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [11:0] pixel_out
    output logic                 m_tlast    // frame_last
);

    logic  q_full, q_nonempty, push, pop;
    step_t push_data, pop_data;

    rcccdm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rcccdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .nonempty  (q_nonempty)
    );

    rcccdm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (pop_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/rcccdm_front.sv]
// ============================================================================
// rcccdm_front: transaction intake and classification
// Holds the configuration registers and frame counters, decides for each
// transaction whether it is a step and whether that step emits a pixel, and
// precomputes the border and red-site flags for the emitted position.
// ============================================================================
module rcccdm_front
    import rcccdm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [11:0] pixel_in
    input  logic                 s_tuser,   // [0] opcode
    input  logic                 q_full,
    output logic                 push,
    output step_t                push_data
);

    logic [CFG_COLS_W-1:0] cols_cfg_reg;
    logic [CFG_ROWS_W-1:0] rows_cfg_reg;
    logic [ORDER_W-1:0]    order_cfg_reg;
    logic [COLS_W-1:0]     act_cols_reg, act_cols_next;
    logic [ROWS_W-1:0]     act_rows_reg, act_rows_next;
    logic [ORDER_W-1:0]    act_order_reg, act_order_next;
    logic [COL_AW-1:0]     in_col_reg, in_col_next;
    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic [COL_AW-1:0]     out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic                  drain_reg, drain_next;

    logic                  acc, step, first, emit, last, red;
    logic [COLS_W-1:0]     cols_sat, cols_eff;
    logic [ROWS_W-1:0]     rows_sat, rows_eff;
    logic [ORDER_W-1:0]    order_eff;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;
    // pixels are taken only outside a drain, drains only inside one
    assign step     = acc && ((s_tuser == OP_DRAIN) ? drain_reg : !drain_reg);
    assign first    = (s_tuser == OP_PIXEL) && (in_col_reg == '0) && (in_row_reg == '0);

    // clamp the geometry registers
    always_comb
    begin
        if (int'(cols_cfg_reg) < MIN_DIM)
            cols_sat = COLS_W'(MIN_DIM);
        else if (int'(cols_cfg_reg) > MAX_COLS)
            cols_sat = COLS_W'(MAX_COLS);
        else
            cols_sat = COLS_W'(cols_cfg_reg);
        if (int'(rows_cfg_reg) < MIN_DIM)
            rows_sat = ROWS_W'(MIN_DIM);
        else if (int'(rows_cfg_reg) > MAX_ROWS)
            rows_sat = ROWS_W'(MAX_ROWS);
        else
            rows_sat = ROWS_W'(rows_cfg_reg);
    end

    assign cols_eff  = first ? cols_sat      : act_cols_reg;
    assign rows_eff  = first ? rows_sat      : act_rows_reg;
    assign order_eff = first ? order_cfg_reg : act_order_reg;

    // output starts two lines and two pixels behind the input
    assign emit = drain_reg || (in_row_reg >= ROW_W'(3))
               || ((in_row_reg == ROW_W'(2)) && (in_col_reg >= COL_AW'(2)));
    assign last = drain_reg
               && (COLS_W'(out_col_reg) + COLS_W'(1) == cols_eff)
               && (ROWS_W'(out_row_reg) + ROWS_W'(1) == rows_eff);
    assign red  = (out_col_reg[0] == order_eff[0]) && (out_row_reg[0] == order_eff[1]);

    // step record
    always_comb
    begin
        push           = step;
        push_data.pix  = s_tdata[PIX_W-1:0];
        push_data.addr = in_col_reg;
        push_data.emit = emit;
        push_data.last = last;
        push_data.red  = red;
        push_data.h    = mirror_flags(DIM_W'(out_col_reg), DIM_W'(cols_eff));
        push_data.v    = mirror_flags(DIM_W'(out_row_reg), DIM_W'(rows_eff));
    end

    // counter update
    always_comb
    begin
        act_cols_next  = act_cols_reg;
        act_rows_next  = act_rows_reg;
        act_order_next = act_order_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        drain_next     = drain_reg;
        if (step)
        begin
            if (first)
            begin
                act_cols_next  = cols_sat;
                act_rows_next  = rows_sat;
                act_order_next = order_cfg_reg;
            end
            if (emit && !last)
            begin
                if (COLS_W'(out_col_reg) + COLS_W'(1) == cols_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                    out_col_next = out_col_reg + COL_AW'(1);
            end
            if (last)
            begin
                out_col_next = '0;
                out_row_next = '0;
                in_col_next  = '0;
                in_row_next  = '0;
                drain_next   = 1'b0;
            end
            else if (COLS_W'(in_col_reg) + COLS_W'(1) == cols_eff)
            begin
                in_col_next = '0;
                if (!drain_reg)
                begin
                    if (ROWS_W'(in_row_reg) + ROWS_W'(1) == rows_eff)
                    begin
                        in_row_next = '0;
                        drain_next  = 1'b1;
                    end
                    else
                        in_row_next = in_row_reg + ROW_W'(1);
                end
            end
            else
                in_col_next = in_col_reg + COL_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg  <= CFG_COLS_W'(MAX_COLS);
            rows_cfg_reg  <= CFG_ROWS_W'(MIN_DIM);
            order_cfg_reg <= '0;
            act_cols_reg  <= COLS_W'(MAX_COLS);
            act_rows_reg  <= ROWS_W'(MIN_DIM);
            act_order_reg <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            drain_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_FRAME_COLS))
                cols_cfg_reg <= cfg_data[CFG_COLS_W-1:0];
            if (cfg_we && (cfg_index == REG_FRAME_ROWS))
                rows_cfg_reg <= cfg_data[CFG_ROWS_W-1:0];
            if (cfg_we && (cfg_index == REG_COLOR_ORDER))
                order_cfg_reg <= cfg_data[ORDER_W-1:0];
            act_cols_reg  <= act_cols_next;
            act_rows_reg  <= act_rows_next;
            act_order_reg <= act_order_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            drain_reg     <= drain_next;
        end
    end

    // pixels arriving during a drain never reach the back end
    a_no_pixel_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (s_tuser == OP_PIXEL) && drain_reg) |-> !push)
        else $error("pixel pushed during drain");

    // frame end always carries a pixel
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.last) |-> push_data.emit)
        else $error("frame end without output");

    // frame end closes the drain
    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.last) |=> !drain_reg)
        else $error("drain still open after frame end");

endmodule

[rtl/rcccdm_queue.sv]
// ============================================================================
// rcccdm_queue: step queue between front and back end
// Small register FIFO that lets either side stall on its own.
// ============================================================================
module rcccdm_queue
    import rcccdm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  step_t push_data,
    output logic  full,
    input  logic  pop,
    output step_t pop_data,
    output logic  nonempty
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    step_t             slot_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   count_reg, count_next;

    assign full     = count_reg == QC_W'(QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QC_W'(1);
        else if (pop && !push)
            count_next = count_reg - QC_W'(1);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                   : wr_ptr_reg + QA_W'(1);
            if (pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                   : rd_ptr_reg + QA_W'(1);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QUEUE_DEPTH)
        else $error("queue overfilled");

endmodule

[rtl/rcccdm_back.sv]
// ============================================================================
// rcccdm_back: line store, 5x5 window and interpolation
// Each step reads its column of four stored lines, shifts a five-line column
// into the window, and emitting steps go through a two-stage estimator into
// the output register.
// ============================================================================
module rcccdm_back
    import rcccdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_nonempty,
    input  step_t              q_data,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [11:0] pixel_out
    output logic               m_tlast    // frame_last
);

    localparam int SUM_W = PIX_W + 1;

    // line store: one entry per column, four older lines, newest lowest
    logic [LINE_W-1:0] line_mem [MAX_COLS];
    logic [LINE_W-1:0] rd_reg;
    logic [LINE_W-1:0] wr_word;

    logic              en, s1_fire;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    step_t             s1_reg, s2_reg;
    logic [PIX_W-1:0]  col_vec [WIN];
    logic [PIX_W-1:0]  win_reg [WIN][WIN];

    logic [PIX_W-1:0]  hfa, hfb, hna, hnb, vfa, vfb, vna, vnb;
    logic [SUM_W-1:0]  hf_sum_reg, vf_sum_reg, hn_sum_reg, vn_sum_reg;
    logic [PIX_W-1:0]  centre_reg;
    logic              red_reg, last_reg;
    logic [SUM_W-1:0]  c2, dh, dv, h_mean, v_mean;
    logic [SUM_W:0]    all_sum;
    logic [PIX_W-1:0]  result;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_last_reg;

    // whole pipeline moves unless the output register is held
    assign en      = !out_valid_reg || m_tready;
    assign pop     = en && q_nonempty;
    assign s1_fire = en && s1_valid_reg;

    // column vector: current pixel over four stored lines
    always_comb
    begin
        col_vec[0] = s1_reg.pix;
        for (int j = 1; j < WIN; j++)
            col_vec[j] = rd_reg[(j-1)*PIX_W +: PIX_W];
    end
    assign wr_word = {rd_reg[(STORE_ROWS-1)*PIX_W-1:0], s1_reg.pix};

    always_ff @(posedge clk)
    begin
        if (pop)
            rd_reg <= line_mem[q_data.addr];
        if (s1_fire)
            line_mem[s1_reg.addr] <= wr_word;
    end

    // window and step payload
    always_ff @(posedge clk)
    begin
        if (pop)
            s1_reg <= q_data;
        if (s1_fire)
        begin
            win_reg[0] <= col_vec;
            for (int k = 1; k < WIN; k++)
                win_reg[k] <= win_reg[k-1];
        end
        if (en)
            s2_reg <= s1_reg;
    end

    // sample selection with border mirroring; column 2 / row 2 is the centre
    always_comb
    begin
        hfa = s2_reg.h.far_a_fwd   ? win_reg[0][2] : win_reg[4][2];
        hfb = s2_reg.h.far_b_back  ? win_reg[4][2] : win_reg[0][2];
        hna = s2_reg.h.near_a_fwd  ? win_reg[1][2] : win_reg[3][2];
        hnb = s2_reg.h.near_b_back ? win_reg[3][2] : win_reg[1][2];
        vfa = s2_reg.v.far_a_fwd   ? win_reg[2][0] : win_reg[2][4];
        vfb = s2_reg.v.far_b_back  ? win_reg[2][4] : win_reg[2][0];
        vna = s2_reg.v.near_a_fwd  ? win_reg[2][1] : win_reg[2][3];
        vnb = s2_reg.v.near_b_back ? win_reg[2][3] : win_reg[2][1];
    end

    // stage 3: pair sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hf_sum_reg <= SUM_W'(hfa) + SUM_W'(hfb);
            vf_sum_reg <= SUM_W'(vfa) + SUM_W'(vfb);
            hn_sum_reg <= SUM_W'(hna) + SUM_W'(hnb);
            vn_sum_reg <= SUM_W'(vna) + SUM_W'(vnb);
            centre_reg <= win_reg[2][2];
            red_reg    <= s2_reg.red;
            last_reg   <= s2_reg.last;
        end
    end

    // gradient compare and estimate
    always_comb
    begin
        c2      = {centre_reg, 1'b0};
        dh      = (hf_sum_reg >= c2) ? hf_sum_reg - c2 : c2 - hf_sum_reg;
        dv      = (vf_sum_reg >= c2) ? vf_sum_reg - c2 : c2 - vf_sum_reg;
        h_mean  = hn_sum_reg + SUM_W'(1);
        v_mean  = vn_sum_reg + SUM_W'(1);
        all_sum = (SUM_W+1)'(hn_sum_reg) + (SUM_W+1)'(vn_sum_reg) + (SUM_W+1)'(2);
        if (!red_reg)
            result = centre_reg;
        else if (dh < dv)
            result = h_mean[SUM_W-1:1];
        else if (dv < dh)
            result = v_mean[SUM_W-1:1];
        else
            result = all_sum[SUM_W:2];
    end

    always_ff @(posedge clk)
    begin
        if (en && s3_valid_reg)
        begin
            out_pix_reg  <= result;
            out_last_reg <= last_reg;
        end
    end

    // stage valid bits; only emitting steps go past the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_nonempty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_reg.emit;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_pix_reg);
    assign m_tlast  = out_last_reg;

    // a held output freezes the queue side
    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !pop)
        else $error("queue popped while output held");

    // the window only moves with a live step
    a_shift_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> s1_valid_reg && en)
        else $error("window shifted without a step");

endmodule
